[hw/rtl/enb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// enb_pkg: shared types and constants of the envelope normalize block
// Block geometry, field widths, controller states and control structs.
// ----------------------------------------------------------------------------
package enb_pkg;

	localparam int BLOCK_LEN = 64;
	localparam int SEGMENTS  = 8;
	localparam int SEG_LEN   = BLOCK_LEN / SEGMENTS;   // power of two
	localparam int SEG_BITS  = $clog2(SEG_LEN);
	localparam int SEGI_W    = $clog2(SEGMENTS);
	localparam int IDX_W     = $clog2(BLOCK_LEN);

	localparam int COEF_W = 24;
	localparam int SUM_W  = 30;
	localparam int ENV_W  = 31;
	localparam int NUM_W  = ENV_W + SEG_BITS + 2;        // interpolated divisor
	localparam int DIV_W  = COEF_W + SEG_BITS + 20;      // |c| * SEG_LEN << 20
	localparam int CNT_W  = $clog2(DIV_W + 1);

	localparam logic [ENV_W-1:0]  ENV_MAX = {ENV_W{1'b1}};
	localparam logic [COEF_W-1:0] Q_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic [COEF_W-1:0] Q_MIN   = {1'b1, {(COEF_W-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_READ,
		ST_NUM,
		ST_START,
		ST_DIV,
		ST_OUT
	} enb_state_t;

	typedef struct packed {
		logic load_en;
		logic blk_done;
		logic rd_en;
		logic num_en;
		logic div_start;
		logic out_load;
	} enb_cmd_t;

	typedef struct packed {
		logic load_last;
		logic idx_last;
		logic out_free;
		logic div_busy;
	} enb_status_t;

	// envelope of one segment sum: sum * 256 / SEG_LEN, saturated
	function automatic logic [ENV_W-1:0] seg_env(input logic [SUM_W-1:0] sum);
		logic [SUM_W+7:0] full;
		full = {sum, 8'd0} >> SEG_BITS;
		if (full > (SUM_W+8)'(ENV_MAX))
			return ENV_MAX;
		return full[ENV_W-1:0];
	endfunction

endpackage
`default_nettype wire

[hw/rtl/enb_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// enb_div: restoring divider, one quotient bit per cycle
// Unsigned DIV_W-bit dividend over NUM_W-bit divisor.
// ----------------------------------------------------------------------------
module enb_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [enb_pkg::DIV_W-1:0] dividend,
	input  wire logic [enb_pkg::NUM_W-1:0] divisor,
	output logic                           busy,
	output logic      [enb_pkg::DIV_W-1:0] quotient
);
	import enb_pkg::*;

	logic [NUM_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [NUM_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? NUM_W'(trial - {1'b0, divisor}) : trial[NUM_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

[hw/rtl/enb_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// enb_ctrl: block sequencer
// Loads a block, then walks the results: read, divisor, divide, emit.
// ----------------------------------------------------------------------------
module enb_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire enb_pkg::enb_status_t status,
	output enb_pkg::enb_cmd_t         cmd
);
	import enb_pkg::*;

	enb_state_t state_q;
	enb_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_LOAD;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_LOAD:  if (in_valid && status.load_last) state_nx = ST_READ;
			ST_READ:  state_nx = ST_NUM;
			ST_NUM:   state_nx = ST_START;
			ST_START: state_nx = ST_DIV;
			ST_DIV:   if (!status.div_busy) state_nx = ST_OUT;
			ST_OUT: begin
				if (status.out_free)
					state_nx = status.idx_last ? ST_LOAD : ST_READ;
			end
			default:  state_nx = ST_LOAD;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_LOAD: begin
				in_stall     = 1'b0;
				cmd.load_en  = in_valid;
				cmd.blk_done = in_valid && status.load_last;
			end
			ST_READ:  cmd.rd_en     = 1'b1;
			ST_NUM:   cmd.num_en    = 1'b1;
			ST_START: cmd.div_start = 1'b1;
			ST_DIV:   ;
			ST_OUT:   cmd.out_load  = status.out_free;
			default:  ;
		endcase
	end

endmodule
`default_nettype wire

[hw/rtl/enb_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// enb_dpath: sample store, segment sums, envelopes, divisor and output reg
// Envelopes sit in a shift line so the current and next segment are taps.
// ----------------------------------------------------------------------------
module enb_dpath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire enb_pkg::enb_cmd_t                 cmd,
	output enb_pkg::enb_status_t                   status,
	input  wire logic signed [enb_pkg::COEF_W-1:0] coefficient,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed      [enb_pkg::COEF_W-1:0] normalized,
	output logic             [enb_pkg::ENV_W-1:0]  envelope,
	output logic                                   is_last
);
	import enb_pkg::*;

	logic signed [COEF_W-1:0] store_q [BLOCK_LEN];
	logic signed [COEF_W-1:0] rd_data_q;
	logic [SUM_W-1:0]  sums_q [SEGMENTS];
	logic [SUM_W-1:0]  sum_nx [SEGMENTS];
	logic [ENV_W-1:0]  env_q  [SEGMENTS];
	logic [IDX_W-1:0]  load_cnt_q;
	logic [IDX_W-1:0]  idx_q;
	logic [COEF_W-1:0] in_mag;
	logic [SEGI_W-1:0] load_seg;
	logic [NUM_W-1:0]  num_q;
	logic [COEF_W-1:0] mag_q;
	logic              neg_q;
	logic [SEG_BITS-1:0] off;
	logic [SEG_BITS:0]   w_cur;
	logic [NUM_W-1:0]  num_nx;
	logic              div_busy;
	logic [DIV_W-1:0]  quo;
	logic [COEF_W-1:0] q_res;
	logic              out_valid_q;
	logic              out_free;
	logic              idx_last;

	// ---- load side
	assign in_mag   = coefficient[COEF_W-1] ? COEF_W'(~coefficient + 1'b1) : coefficient;
	assign load_seg = load_cnt_q[IDX_W-1:SEG_BITS];

	always_comb begin
		for (int i = 0; i < SEGMENTS; i++)
			sum_nx[i] = (SEGI_W'(i) == load_seg) ? SUM_W'(sums_q[i] + SUM_W'(in_mag))
			                                     : sums_q[i];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_en)
			store_q[load_cnt_q] <= coefficient;
		if (cmd.rd_en)
			rd_data_q <= store_q[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			for (int i = 0; i < SEGMENTS; i++)
				sums_q[i] <= '0;
		end else if (cmd.blk_done) begin
			load_cnt_q <= '0;
			for (int i = 0; i < SEGMENTS; i++)
				sums_q[i] <= '0;
		end else if (cmd.load_en) begin
			load_cnt_q <= load_cnt_q + 1'b1;
			sums_q     <= sum_nx;
		end
	end

	// ---- envelope shift line; last tap holds so the final segment sees itself
	assign off      = idx_q[SEG_BITS-1:0];
	assign idx_last = idx_q == IDX_W'(BLOCK_LEN - 1);

	always_ff @(posedge clk) begin
		if (cmd.blk_done) begin
			for (int i = 0; i < SEGMENTS; i++)
				env_q[i] <= seg_env(sum_nx[i]);
		end else if (cmd.out_load && off == SEG_BITS'(SEG_LEN - 1)) begin
			for (int i = 0; i < SEGMENTS - 1; i++)
				env_q[i] <= env_q[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= '0;
		else if (cmd.out_load)
			idx_q <= idx_last ? '0 : idx_q + 1'b1;
	end

	// ---- interpolated divisor
	assign w_cur  = (SEG_BITS+1)'(SEG_LEN) - {1'b0, off};
	assign num_nx = NUM_W'(w_cur) * NUM_W'(env_q[0]) + NUM_W'(off) * NUM_W'(env_q[1]);

	always_ff @(posedge clk) begin
		if (cmd.num_en) begin
			num_q <= num_nx;
			neg_q <= rd_data_q[COEF_W-1];
			mag_q <= rd_data_q[COEF_W-1] ? COEF_W'(~rd_data_q + 1'b1) : rd_data_q;
		end
	end

	enb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({mag_q, {(SEG_BITS + 20){1'b0}}}),
		.divisor  (num_q),
		.busy     (div_busy),
		.quotient (quo)
	);

	// ---- saturate and sign
	always_comb begin
		if (num_q == '0)
			q_res = '0;
		else if (neg_q)
			q_res = (quo > DIV_W'(Q_MIN)) ? Q_MIN : COEF_W'(~quo[COEF_W-1:0] + 1'b1);
		else
			q_res = (quo > DIV_W'(Q_MAX)) ? Q_MAX : quo[COEF_W-1:0];
	end

	// ---- output register
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			normalized <= q_res;
			envelope   <= env_q[0];
			is_last    <= idx_last;
		end
	end

	assign out_valid        = out_valid_q;
	assign status.load_last = load_cnt_q == IDX_W'(BLOCK_LEN - 1);
	assign status.idx_last  = idx_last;
	assign status.out_free  = out_free;
	assign status.div_busy  = div_busy;

endmodule
`default_nettype wire

[hw/rtl/envelope_normalize_block.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// envelope_normalize_block: mean-absolute envelope gain normalization
//
// Input channel (in_valid / in_stall, coefficient): one signed coefficient per
// beat, BLOCK_LEN beats make a block. Loading accepts one beat per cycle and
// gives no results. The beat that completes the block latches the segment
// envelopes and stalls the input until its last result is in the output reg.
// Output channel (out_valid / out_stall): BLOCK_LEN result beats in block
// order, each with normalized value, its segment envelope and is_last on the
// final beat. Each result goes through store read, divisor build, divider
// start, one bit-serial divider step per quotient bit, a check that the
// divider is idle, and output load. The divider dominates the time per result.
// The output register holds a result while out_stall is high; the sequencer
// waits on it before loading the next. The last result may still wait while
// the next block already loads.
// Reset clears the sequencer, counters, segment sums and output valid; the
// sample store needs no clearing since it is fully written before any read.
// ----------------------------------------------------------------------------
module envelope_normalize_block (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [enb_pkg::COEF_W-1:0] coefficient,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed      [enb_pkg::COEF_W-1:0] normalized,
	output logic             [enb_pkg::ENV_W-1:0]  envelope,
	output logic                                   is_last
);
	import enb_pkg::*;

	enb_cmd_t    cmd;
	enb_status_t status;

	// sequencer
	enb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// storage, envelopes, divider and result register
	enb_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.coefficient (coefficient),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.normalized  (normalized),
		.envelope    (envelope),
		.is_last     (is_last)
	);

endmodule
`default_nettype wire

[hw/rtl/enb_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// enb_checker: port-level checks of the envelope normalize block
// Bound to the top level.
// ----------------------------------------------------------------------------
module enb_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_stall,
	input wire logic signed [enb_pkg::COEF_W-1:0] coefficient,
	input wire logic                              out_valid,
	input wire logic                              out_stall,
	input wire logic signed [enb_pkg::COEF_W-1:0] normalized,
	input wire logic        [enb_pkg::ENV_W-1:0]  envelope,
	input wire logic                              is_last
);
	import enb_pkg::*;

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(normalized)
			&& $stable(envelope) && $stable(is_last))
		else $error("stalled result beat changed");

	// stalled input beat holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(coefficient))
		else $error("stalled input beat changed");

	// no loading while a block is being emitted
	a_no_load_mid_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_last |-> in_stall)
		else $error("input taken in the middle of a result block");

	// after the last beat of a block nothing follows until a new block loads
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && is_last |=> !out_valid)
		else $error("result beat right after end of block");

endmodule

bind envelope_normalize_block enb_checker u_enb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.coefficient (coefficient),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.normalized  (normalized),
	.envelope    (envelope),
	.is_last     (is_last)
);
`default_nettype wire
